FILE: rtl/mwrms_pkg.sv
package mwrms_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RMS_W      = 16;
   localparam int MEAN_W     = 31;
   localparam int SQUARE_W   = 31;

   // bit-serial root: two radicand bits per step
   localparam int ROOT_STEPS = 16;
   localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
   localparam int ROOT_ACC_W = 32;
   localparam logic [MEAN_W-1:0] ROOT_TOP_BIT = {1'b1, {(MEAN_W-1){1'b0}}};

   typedef struct packed {
      logic              start;
      logic [MEAN_W-1:0] operand;
   } isqrt_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [RMS_W-1:0] root;
   } isqrt_stat_type;

endpackage

FILE: rtl/moving_window_rms_core.sv
// The mean is a shift of the running sum when WINDOW_DEPTH is a power of two, else a
// reciprocal multiply by the depth, one byte of the sum per cycle. The 16-step bit-serial
// square root of the mean follows.
// One sample is in flight at a time: a new word is taken only after the previous result is
// registered, which waits while the receiver stalls an earlier result.
// Synchronous reset clears the window (per-entry valid bits), the running sum and the position.
module moving_window_rms_core import mwrms_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RMS_W-1:0]    rsp_rms_value,
   output logic [MEAN_W-1:0]   rsp_mean_square
);

   localparam int POS_W       = $clog2(WINDOW_DEPTH);
   localparam int TOTAL_W     = SQUARE_W + $clog2(WINDOW_DEPTH);
   localparam int DIGITS      = (TOTAL_W + 7) / 8;
   localparam int NUM_W       = 8 * DIGITS;
   localparam int RECIP_W     = TOTAL_W + 1;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_DEPTH);
   localparam int DCNT_W      = $clog2(DIGITS + 1);
   localparam bit IS_POW2     = (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0;
   localparam logic [63:0] RECIP_NUM = 64'd1 << RECIP_SHIFT;
   // ceil(2^RECIP_SHIFT / depth): exact floor quotient for any sum below 2^TOTAL_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((RECIP_NUM + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
   localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(WINDOW_DEPTH - 1);
   localparam logic [DCNT_W-1:0]  DIV_STEPS = DCNT_W'(DIGITS);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(WINDOW_DEPTH) << (SQUARE_W - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [SQUARE_W-1:0]     square_ff, square_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic [MEAN_W-1:0]       mean_ff, mean_in;
   logic [RMS_W-1:0]        root_ff, root_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]        rsp_rms_ff, rsp_rms_in;
   logic [MEAN_W-1:0]       rsp_mean_ff, rsp_mean_in;

   logic                    accept;
   logic [SAMPLE_W-1:0]     magnitude;
   logic [2*SAMPLE_W-1:0]   product;
   logic [SQUARE_W-1:0]     ram_rd_data;
   logic [SQUARE_W-1:0]     oldest;
   logic                    ram_wr_en;
   logic [RECIP_W+7:0]      partial;
   logic [MEAN_W-1:0]       shift_mean;
   isqrt_ctrl_type          sq_ctrl;
   isqrt_stat_type          sq_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // -32768 maps to 0x8000, still correct as unsigned
   assign magnitude = req_sample[SAMPLE_W-1] ? (~req_sample + 1'b1) : req_sample;
   assign product   = magnitude * magnitude;
   assign square_in = accept ? product[SQUARE_W-1:0] : square_ff;

   // entries never written since reset read as zero
   assign oldest     = valid_ff[pos_ff] ? ram_rd_data : '0;
   assign ram_wr_en  = (state_ff == ST_UPDATE);
   assign partial    = num_ff[NUM_W-1 -: 8] * RECIP;
   assign shift_mean = MEAN_W'(total_ff >> $clog2(WINDOW_DEPTH));

   mwrms_ram #(
      .WIDTH(SQUARE_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (square_ff),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   mwrms_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .ctrl  (sq_ctrl),
      .stat  (sq_stat)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      dcnt_in      = dcnt_ff;
      mean_in      = mean_ff;
      root_in      = root_ff;
      rsp_rms_in   = rsp_rms_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sq_ctrl.start   = 1'b0;
      sq_ctrl.operand = mean_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            total_in        = total_ff - TOTAL_W'(oldest) + TOTAL_W'(square_ff);
            num_in          = NUM_W'(total_in);
            prod_in         = '0;
            dcnt_in         = '0;
            valid_in[pos_ff] = 1'b1;
            pos_in          = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
            state_in        = ST_DIV;
         end
         ST_DIV: begin
            if (IS_POW2) begin
               mean_in         = shift_mean;
               sq_ctrl.start   = 1'b1;
               sq_ctrl.operand = shift_mean;
               state_in        = ST_ROOT;
            end else if (dcnt_ff == DIV_STEPS) begin
               mean_in         = prod_ff[RECIP_SHIFT +: MEAN_W];
               sq_ctrl.start   = 1'b1;
               sq_ctrl.operand = prod_ff[RECIP_SHIFT +: MEAN_W];
               state_in        = ST_ROOT;
            end else begin
               // reciprocal multiply, top byte of the sum first
               prod_in = (prod_ff << 8) + PROD_W'(partial);
               num_in  = num_ff << 8;
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (sq_stat.done) begin
               root_in  = sq_stat.root;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = root_ff;
               rsp_mean_in  = mean_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      square_ff   <= square_in;
      num_ff      <= num_in;
      prod_ff     <= prod_in;
      dcnt_ff     <= dcnt_in;
      mean_ff     <= mean_in;
      root_ff     <= root_in;
      rsp_rms_ff  <= rsp_rms_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rms_value   = rsp_rms_ff;
   assign rsp_mean_square = rsp_mean_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_MAX)
      else $error("running sum above full-scale window");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("write position past end of window");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_UPDATE)
      else $error("accepted word not followed by window update");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({16'b0, rsp_rms_ff} * {16'b0, rsp_rms_ff} <= 32'(rsp_mean_ff))
         && ((34'(rsp_rms_ff) + 34'd1) * (34'(rsp_rms_ff) + 34'd1) > 34'(rsp_mean_ff)))
      else $error("root is not the floor square root of the mean");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_mean_ff <= ROOT_TOP_BIT >> 0 - MEAN_W'(0) && !rsp_mean_ff[MEAN_W-1]
         || rsp_mean_ff == (ROOT_TOP_BIT >> 0))
      else $error("mean of squares above full scale");

endmodule

FILE: rtl/mwrms_ram.sv
module mwrms_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mwrms_isqrt.sv
module mwrms_isqrt import mwrms_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  isqrt_ctrl_type ctrl,
   output isqrt_stat_type stat
);

   logic [ROOT_ACC_W-1:0] rem_ff, rem_in;
   logic [ROOT_ACC_W-1:0] root_ff, root_in;
   logic [MEAN_W-1:0]     bit_ff, bit_in;
   logic [ROOT_CNT_W-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_ACC_W-1:0] trial;

   assign trial = root_ff + ROOT_ACC_W'(bit_ff);

   always_comb begin
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         rem_in   = ROOT_ACC_W'(ctrl.operand);
         root_in  = '0;
         bit_in   = ROOT_TOP_BIT;
         count_in = ROOT_CNT_W'(ROOT_STEPS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + ROOT_ACC_W'(bit_ff);
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in   = bit_ff >> 2;
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      count_ff <= count_in;
   end

   assign stat.done = done_ff;
   assign stat.root = root_ff[RMS_W-1:0];

endmodule

FILE: verif/testbench.sv
module testbench;
   import mwrms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [RMS_W-1:0]  rms_value;
      logic [MEAN_W-1:0] mean_square;
   } rms_word_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [RMS_W-1:0]    rsp_rms_value;
   logic [MEAN_W-1:0]   rsp_mean_square;

   // local copy of the window state
   logic [SQUARE_W-1:0] square_ring [DEPTH];
   int unsigned         ring_pos;
   logic [34:0]         window_sum;

   rms_word_type expected_words[$];
   int           mismatch_count;
   int           burst_left;
   int           ready_hold;

   moving_window_rms_core #(
      .WINDOW_DEPTH(DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rms_value  (rsp_rms_value),
      .rsp_mean_square(rsp_mean_square)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // floor square root, built one result bit at a time from the top
   function automatic logic [RMS_W-1:0] floor_root(input logic [MEAN_W-1:0] v);
      logic [16:0] root;
      logic [16:0] trial;
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (17'd1 << b);
         if (64'(trial) * 64'(trial) <= 64'(v))
            root = trial;
      end
      return root[RMS_W-1:0];
   endfunction

   task automatic window_rms_predict(input logic [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W-1:0] sv;
      logic [16:0]                mag;
      logic [SQUARE_W-1:0]        sq;
      logic [34:0]                mean;
      rms_word_type               w;
      sv = s;
      mag = sv[SAMPLE_W-1] ? 17'(-18'(sv)) : 17'(sv);
      sq = SQUARE_W'(64'(mag) * 64'(mag));
      window_sum = window_sum - 35'(square_ring[ring_pos]) + 35'(sq);
      square_ring[ring_pos] = sq;
      ring_pos = (ring_pos + 1 >= DEPTH) ? 0 : ring_pos + 1;
      mean = window_sum / DEPTH;
      w.mean_square = mean[MEAN_W-1:0];
      w.rms_value = floor_root(w.mean_square);
      expected_words.push_back(w);
   endtask

   // one word out; valid stays up inside a burst, drops only for a gap
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= s;
      do
         @(posedge clock);
      while (!req_ready);
      window_rms_predict(s);
   endtask

   task automatic test_field_extremes();
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'hffff);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h8001);
      send_sample(16'h5555);
      send_sample(16'haaaa);
   endtask

   // most negative sample across the whole window and past the wrap: top mean and root
   task automatic test_full_scale_window();
      repeat (DEPTH + 1) send_sample(16'h8000);
   endtask

   task automatic test_random_samples(input int count);
      int                  kind;
      int                  run;
      logic [SAMPLE_W-1:0] dc;
      logic [SAMPLE_W-1:0] s;
      while (count > 0) begin
         kind = $urandom_range(0, 5);
         run  = $urandom_range(8, 40);
         dc   = 16'($urandom);
         for (int i = 0; i < run && count > 0; i++) begin
            case (kind)
               0: s = 16'($urandom);
               1: s = 16'($signed(9'($urandom)));
               2: s = $urandom_range(0, 1) ? 16'($urandom_range(32000, 32767))
                                           : 16'(-$urandom_range(32000, 32768));
               3: s = dc;
               4: s = i[0] ? dc : 16'(-$signed(dc));
               default: s = $urandom_range(0, 3) == 0 ? 16'h8000 : 16'($urandom);
            endcase
            send_sample(s);
            count--;
         end
      end
   endtask

   // receiver stall pattern: hold each ready level for a random stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!rsp_ready) begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 40);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 4);
      end
   end

   always @(posedge clock) begin
      rms_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word rms=%0d mean=%0d", $time,
                     rsp_rms_value, rsp_mean_square);
            mismatch_count++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_rms_value !== w.rms_value) begin
               $display("%0t: rms_value expected %0d actual %0d", $time,
                        w.rms_value, rsp_rms_value);
               mismatch_count++;
            end
            if (rsp_mean_square !== w.mean_square) begin
               $display("%0t: mean_square expected %0d actual %0d", $time,
                        w.mean_square, rsp_mean_square);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample     = '0;
      burst_left     = 0;
      ring_pos       = 0;
      window_sum     = '0;
      foreach (square_ring[i]) square_ring[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_full_scale_window();
      test_random_samples(650);
      req_valid <= 1'b0;

      wait (expected_words.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
